[src/sbia_pkg.sv]
`default_nettype none

package sbia_pkg;

  // Field widths
  localparam int unsigned MvW     = 12;
  localparam int unsigned TickW   = 6;
  localparam int unsigned CountW  = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaskW   = 4;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_DARK_THRESHOLD = 3'd0,
    REG_OFF_BAND_TOP   = 3'd1,
    REG_AUTO_BAND_TOP  = 3'd2,
    REG_ON_DELAY       = 3'd3,
    REG_OFF_DELAY      = 3'd4,
    REG_TICK           = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [MvW-1:0]   DarkThresholdRst = 12'd200;
  localparam logic [MvW-1:0]   OffBandTopRst    = 12'd1056;
  localparam logic [MvW-1:0]   AutoBandTopRst   = 12'd2112;
  localparam logic [MvW-1:0]   OnDelayRst       = 12'd1000;
  localparam logic [MvW-1:0]   OffDelayRst      = 12'd2000;
  localparam logic [TickW-1:0] TickRst          = 6'd25;

  typedef struct packed {
    logic [MvW-1:0]   dark_threshold_mv;
    logic [MvW-1:0]   off_band_top_mv;
    logic [MvW-1:0]   auto_band_top_mv;
    logic [MvW-1:0]   on_delay_ms;
    logic [MvW-1:0]   off_delay_ms;
    logic [TickW-1:0] tick_ms;
  } cfg_t;

  typedef struct packed {
    logic              seat_was_taken;
    logic              button_was_held;
    logic              engine_running;
    logic              beams_lit;
    logic              auto_was_selected;
    logic              dark_before;
    logic [CountW-1:0] delay_count_ms;
  } state_t;

  typedef struct packed {
    logic           driver_seated;
    logic           driver_belted;
    logic           passenger_seated;
    logic           passenger_belted;
    logic           start_button;
    logic [MvW-1:0] selector_mv;
    logic [MvW-1:0] ambient_mv;
  } item_t;

  typedef struct packed {
    logic             ready_led;
    logic             engine_led;
    logic             dipped_beam;
    logic             inhibit_pulse;
    logic [MaskW-1:0] missing_mask;
    logic             welcome_pulse;
    logic             started_pulse;
  } result_t;

endpackage

`default_nettype wire

[src/sbia_step.sv]
`default_nettype none

module sbia_step import sbia_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t res_o
);

  logic              was_running;
  logic              sel_off;
  logic              sel_auto;
  logic              sel_on;
  logic              dark;
  logic              all_ok;
  logic              edge_det;
  logic              ready;
  logic              started;
  logic              inhibit;
  logic [MaskW-1:0]  mask;
  logic              running;
  logic              beams;
  logic [CountW-1:0] cnt;
  logic [CountW-1:0] tick_ext;

  always_comb begin
    was_running = state_i.engine_running;
    sel_off  = (item_i.selector_mv < cfg_i.off_band_top_mv) && was_running;
    sel_auto = (item_i.selector_mv < cfg_i.auto_band_top_mv) &&
               (item_i.selector_mv >= cfg_i.off_band_top_mv) && was_running;
    sel_on   = (item_i.selector_mv >= cfg_i.auto_band_top_mv) && was_running;
    dark     = item_i.ambient_mv < cfg_i.dark_threshold_mv;
    all_ok   = item_i.driver_seated && item_i.driver_belted &&
               item_i.passenger_seated && item_i.passenger_belted;
    edge_det = item_i.start_button && !state_i.button_was_held;
    ready    = all_ok && !was_running;
    started  = 1'b0;
    inhibit  = 1'b0;
    mask     = '0;
    running  = was_running;
    beams    = state_i.beams_lit;
    cnt      = state_i.delay_count_ms;
    tick_ext = CountW'(cfg_i.tick_ms);

    // Ignition press: start, stop or refuse
    if (edge_det) begin
      if (all_ok && !was_running) begin
        running = 1'b1;
        started = 1'b1;
        ready   = 1'b0;
      end else if (was_running) begin
        running = 1'b0;
      end else begin
        inhibit = 1'b1;
        mask    = {!item_i.passenger_belted, !item_i.passenger_seated,
                   !item_i.driver_belted, !item_i.driver_seated};
      end
    end

    // Selector bands and the auto beam timer
    if (sel_off) begin
      beams = 1'b0;
    end else if (sel_on) begin
      beams = 1'b1;
    end else if (sel_auto) begin
      if (!state_i.auto_was_selected) begin
        beams = 1'b0;
      end
      if (!beams && dark && !state_i.dark_before) begin
        cnt = '0;
      end else if (beams && !dark && state_i.dark_before) begin
        cnt = CountW'(cfg_i.off_delay_ms);
      end

      if (dark && !beams) begin
        if (cnt < CountW'(cfg_i.on_delay_ms)) begin
          // wrap at the counter width
          cnt = cnt + tick_ext;
        end else begin
          beams = 1'b1;
          cnt   = CountW'(cfg_i.off_delay_ms);
        end
      end else if (!dark && beams) begin
        if (cnt != '0) begin
          cnt = (cnt > tick_ext) ? cnt - tick_ext : '0;
        end else begin
          beams = 1'b0;
          cnt   = '0;
        end
      end
    end

    state_o.seat_was_taken    = item_i.driver_seated;
    state_o.button_was_held   = item_i.start_button;
    state_o.engine_running    = running;
    state_o.beams_lit         = beams;
    state_o.auto_was_selected = sel_auto;
    state_o.dark_before       = dark;
    state_o.delay_count_ms    = cnt;

    res_o.ready_led     = ready;
    res_o.engine_led    = running;
    res_o.dipped_beam   = beams;
    res_o.inhibit_pulse = inhibit;
    res_o.missing_mask  = mask;
    res_o.welcome_pulse = item_i.driver_seated && !state_i.seat_was_taken;
    res_o.started_pulse = started;
  end

endmodule

`default_nettype wire

[src/seatbelt_interlock_auto_headlights_core.sv]
// A word accepted at a clock edge enters the input register, passes the tick logic, and its
// result is registered in the result register once that register is free or being drained.
// Throughput: one word per cycle while results are taken. A stalled result lets one more
// word wait in the input register, then input ready drops until the result is taken.
// Reset (rst_ni low, asynchronous): both stages empty, all tick state cleared,
// configuration registers back to their default values.
`default_nettype none

module seatbelt_interlock_auto_headlights_core import sbia_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [MvW-1:0]     cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               driver_seated_i,
  input  wire logic               driver_belted_i,
  input  wire logic               passenger_seated_i,
  input  wire logic               passenger_belted_i,
  input  wire logic               start_button_i,
  input  wire logic [MvW-1:0]     selector_mv_i,
  input  wire logic [MvW-1:0]     ambient_mv_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    ready_led_o,
  output logic                    engine_led_o,
  output logic                    dipped_beam_o,
  output logic                    inhibit_pulse_o,
  output logic [MaskW-1:0]        missing_mask_o,
  output logic                    welcome_pulse_o,
  output logic                    started_pulse_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold_mv <= DarkThresholdRst;
      cfg_q.off_band_top_mv   <= OffBandTopRst;
      cfg_q.auto_band_top_mv  <= AutoBandTopRst;
      cfg_q.on_delay_ms       <= OnDelayRst;
      cfg_q.off_delay_ms      <= OffDelayRst;
      cfg_q.tick_ms           <= TickRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DARK_THRESHOLD: cfg_q.dark_threshold_mv <= cfg_data_i;
        REG_OFF_BAND_TOP:   cfg_q.off_band_top_mv   <= cfg_data_i;
        REG_AUTO_BAND_TOP:  cfg_q.auto_band_top_mv  <= cfg_data_i;
        REG_ON_DELAY:       cfg_q.on_delay_ms       <= cfg_data_i;
        REG_OFF_DELAY:      cfg_q.off_delay_ms      <= cfg_data_i;
        REG_TICK:           cfg_q.tick_ms           <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Advance a word when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.driver_seated    <= driver_seated_i;
      item_q.driver_belted    <= driver_belted_i;
      item_q.passenger_seated <= passenger_seated_i;
      item_q.passenger_belted <= passenger_belted_i;
      item_q.start_button     <= start_button_i;
      item_q.selector_mv      <= selector_mv_i;
      item_q.ambient_mv       <= ambient_mv_i;
    end
  end

  sbia_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Commit tick state as the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ready_led_o     = res_q.ready_led;
  assign engine_led_o    = res_q.engine_led;
  assign dipped_beam_o   = res_q.dipped_beam;
  assign inhibit_pulse_o = res_q.inhibit_pulse;
  assign missing_mask_o  = res_q.missing_mask;
  assign welcome_pulse_o = res_q.welcome_pulse;
  assign started_pulse_o = res_q.started_pulse;

  // Checks
  a_started_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && started_pulse_o |-> engine_led_o && !ready_led_o)
    else $error("started word without engine running");

  a_mask_needs_inhibit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inhibit_pulse_o |-> missing_mask_o == '0)
    else $error("missing mask set without inhibit");

  a_ready_engine_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ready_led_o |-> !engine_led_o && !inhibit_pulse_o)
    else $error("ready shown with engine running or inhibit");

  a_state_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("tick state changed without a word advancing");

endmodule

`default_nettype wire

[tb/seatbelt_interlock_auto_headlights_core_tb.sv]
module seatbelt_interlock_auto_headlights_core_tb;
  import sbia_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseWords  = 97;
  localparam int unsigned ItemW       = $bits(item_t);

  // Indexes that decode to no register
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  // Selector bands as the block sees them
  typedef enum int {
    BAND_OFF,
    BAND_AUTO,
    BAND_ON,
    BAND_ANY
  } sel_band_e;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i          = '0;
  logic [MvW-1:0]     cfg_data_i         = '0;
  logic               in_valid_i         = 1'b0;
  logic               in_ready_o;
  logic               driver_seated_i    = 1'b0;
  logic               driver_belted_i    = 1'b0;
  logic               passenger_seated_i = 1'b0;
  logic               passenger_belted_i = 1'b0;
  logic               start_button_i     = 1'b0;
  logic [MvW-1:0]     selector_mv_i      = '0;
  logic [MvW-1:0]     ambient_mv_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i        = 1'b0;
  logic               ready_led_o;
  logic               engine_led_o;
  logic               dipped_beam_o;
  logic               inhibit_pulse_o;
  logic [MaskW-1:0]   missing_mask_o;
  logic               welcome_pulse_o;
  logic               started_pulse_o;

  seatbelt_interlock_auto_headlights_core u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .driver_seated_i,
    .driver_belted_i,
    .passenger_seated_i,
    .passenger_belted_i,
    .start_button_i,
    .selector_mv_i,
    .ambient_mv_i,
    .out_valid_o,
    .out_ready_i,
    .ready_led_o,
    .engine_led_o,
    .dipped_beam_o,
    .inhibit_pulse_o,
    .missing_mask_o,
    .welcome_pulse_o,
    .started_pulse_o
  );

  // Shadow copy of the registers and of the tick state
  cfg_t   lamp_cfg = '{
    dark_threshold_mv: DarkThresholdRst,
    off_band_top_mv:   OffBandTopRst,
    auto_band_top_mv:  AutoBandTopRst,
    on_delay_ms:       OnDelayRst,
    off_delay_ms:      OffDelayRst,
    tick_ms:           TickRst
  };
  state_t cabin = '0;

  result_t     dash_due_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady_run     = 1'b0;

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, dash_due_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Work out the dashboard word for one tick and advance the shadow state
  function automatic result_t next_dash(input item_t w);
    result_t r;
    logic    was_running;
    logic    auto_prev;
    logic    dark_prev;
    logic    dark;
    logic    all_ok;
    logic    press;
    logic    sel_off;
    logic    sel_on;
    logic    sel_auto;
    was_running = cabin.engine_running;
    auto_prev   = cabin.auto_was_selected;
    dark_prev   = cabin.dark_before;
    dark        = w.ambient_mv < lamp_cfg.dark_threshold_mv;
    all_ok      = w.driver_seated & w.driver_belted & w.passenger_seated & w.passenger_belted;
    press       = w.start_button & ~cabin.button_was_held;
    sel_off     = was_running && (w.selector_mv < lamp_cfg.off_band_top_mv);
    sel_on      = was_running && (w.selector_mv >= lamp_cfg.auto_band_top_mv);
    sel_auto    = was_running && !sel_on && (w.selector_mv >= lamp_cfg.off_band_top_mv);

    r = '0;
    r.ready_led     = all_ok && !was_running;
    r.welcome_pulse = w.driver_seated && !cabin.seat_was_taken;

    // Button press: start, stop or refuse
    if (press) begin
      if (all_ok && !was_running) begin
        cabin.engine_running = 1'b1;
        r.started_pulse      = 1'b1;
        r.ready_led          = 1'b0;
      end else if (was_running) begin
        cabin.engine_running = 1'b0;
      end else begin
        r.inhibit_pulse = 1'b1;
        r.missing_mask  = ~{w.passenger_belted, w.passenger_seated,
                            w.driver_belted, w.driver_seated};
      end
    end

    // Beams: forced bands, else the auto on/off delays
    if (sel_off) begin
      cabin.beams_lit = 1'b0;
    end else if (sel_on) begin
      cabin.beams_lit = 1'b1;
    end else if (sel_auto) begin
      if (!auto_prev) cabin.beams_lit = 1'b0;
      if (!cabin.beams_lit && dark && !dark_prev) begin
        cabin.delay_count_ms = '0;
      end else if (cabin.beams_lit && !dark && dark_prev) begin
        cabin.delay_count_ms = CountW'(lamp_cfg.off_delay_ms);
      end
      if (dark && !cabin.beams_lit) begin
        if (cabin.delay_count_ms < lamp_cfg.on_delay_ms) begin
          cabin.delay_count_ms = cabin.delay_count_ms + CountW'(lamp_cfg.tick_ms);
        end else begin
          cabin.beams_lit      = 1'b1;
          cabin.delay_count_ms = CountW'(lamp_cfg.off_delay_ms);
        end
      end else if (!dark && cabin.beams_lit) begin
        if (cabin.delay_count_ms > 0) begin
          // saturate at zero rather than wrap
          if (cabin.delay_count_ms > lamp_cfg.tick_ms) begin
            cabin.delay_count_ms = cabin.delay_count_ms - CountW'(lamp_cfg.tick_ms);
          end else begin
            cabin.delay_count_ms = '0;
          end
        end else begin
          cabin.beams_lit      = 1'b0;
          cabin.delay_count_ms = '0;
        end
      end
    end

    cabin.seat_was_taken    = w.driver_seated;
    cabin.button_was_held   = w.start_button;
    cabin.auto_was_selected = sel_auto;
    cabin.dark_before       = dark;

    r.engine_led  = cabin.engine_running;
    r.dipped_beam = cabin.beams_lit;
    return r;
  endfunction

  function automatic item_t mk(input logic ds, input logic db, input logic ps,
                               input logic pb, input logic btn,
                               input int sel, input int amb);
    item_t w;
    w.driver_seated    = ds;
    w.driver_belted    = db;
    w.passenger_seated = ps;
    w.passenger_belted = pb;
    w.start_button     = btn;
    w.selector_mv      = MvW'(sel);
    w.ambient_mv       = MvW'(amb);
    return w;
  endfunction

  function automatic cfg_t make_cfg(input int dark, input int off_top, input int auto_top,
                                    input int on_d, input int off_d, input int tick);
    cfg_t c;
    c.dark_threshold_mv = MvW'(dark);
    c.off_band_top_mv   = MvW'(off_top);
    c.auto_band_top_mv  = MvW'(auto_top);
    c.on_delay_ms       = MvW'(on_d);
    c.off_delay_ms      = MvW'(off_d);
    c.tick_ms           = TickW'(tick);
    return c;
  endfunction

  // Value in [lo, hi], leaning on the ends; anything when the span is empty
  function automatic logic [MvW-1:0] in_span(input int lo, input int hi);
    if (lo > hi) return MvW'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0:       return MvW'(lo);
      1:       return MvW'(hi);
      default: return MvW'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Send one word and predict its dashboard word on acceptance
  task automatic send_word(input item_t w);
    int unsigned gap;
    gap = steady_run ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    driver_seated_i    <= w.driver_seated;
    driver_belted_i    <= w.driver_belted;
    passenger_seated_i <= w.passenger_seated;
    passenger_belted_i <= w.passenger_belted;
    start_button_i     <= w.start_button;
    selector_mv_i      <= w.selector_mv;
    ambient_mv_i       <= w.ambient_mv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    dash_due_q.push_back(next_dash(w));
  endtask

  // Drop valid and let every outstanding word come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (dash_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write every register, then the two spare indexes, with the block idle
  task automatic apply_config(input cfg_t c);
    logic [CfgIdxW-1:0] idx_list[8];
    logic [MvW-1:0]     val_list[8];
    idx_list = '{REG_DARK_THRESHOLD, REG_OFF_BAND_TOP, REG_AUTO_BAND_TOP, REG_ON_DELAY,
                 REG_OFF_DELAY, REG_TICK, RegSpareLo, RegSpareHi};
    val_list = '{c.dark_threshold_mv, c.off_band_top_mv, c.auto_band_top_mv,
                 c.on_delay_ms, c.off_delay_ms,
                 {6'($urandom), c.tick_ms},
                 MvW'($urandom), MvW'($urandom)};
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[k];
      cfg_data_i <= val_list[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    lamp_cfg = c;
  endtask

  // Random cabin: mostly crew belted in with sticky bands, some noise
  task automatic drive_scene(input int n_words);
    item_t     w;
    sel_band_e band;
    bit        amb_dark;
    int        band_hold;
    int        amb_hold;
    logic      btn;
    band_hold = 0;
    amb_hold  = 0;
    btn       = 1'b0;
    band      = BAND_ANY;
    amb_dark  = 1'b0;
    for (int i = 0; i < n_words; i++) begin
      if (i % 50 == 0) steady_run = ($urandom_range(0, 3) == 0);
      if (band_hold == 0) begin
        case ($urandom_range(0, 5))
          0:       band = BAND_OFF;
          1:       band = BAND_ON;
          5:       band = BAND_ANY;
          default: band = BAND_AUTO;
        endcase
        band_hold = $urandom_range(1, 40);
      end
      if (amb_hold == 0) begin
        amb_dark = 1'($urandom_range(0, 1));
        amb_hold = $urandom_range(1, 70);
      end
      band_hold--;
      amb_hold--;
      if ($urandom_range(0, 7) == 0) btn = ~btn;

      if ($urandom_range(0, 9) == 0) begin
        w = ItemW'($urandom);
      end else begin
        w = mk(1'b1, 1'b1, 1'b1, 1'b1, btn, 0, 0);
        if ($urandom_range(0, 4) == 0) begin
          {w.driver_seated, w.driver_belted, w.passenger_seated, w.passenger_belted} =
            4'($urandom);
        end
        case (band)
          BAND_OFF:  w.selector_mv = in_span(0, int'(lamp_cfg.off_band_top_mv) - 1);
          BAND_AUTO: w.selector_mv = in_span(int'(lamp_cfg.off_band_top_mv),
                                             int'(lamp_cfg.auto_band_top_mv) - 1);
          BAND_ON:   w.selector_mv = in_span(int'(lamp_cfg.auto_band_top_mv), 4095);
          default:   w.selector_mv = MvW'($urandom);
        endcase
        if (amb_dark) begin
          w.ambient_mv = in_span(0, int'(lamp_cfg.dark_threshold_mv) - 1);
        end else begin
          w.ambient_mv = in_span(int'(lamp_cfg.dark_threshold_mv), 4095);
        end
      end
      send_word(w);
    end
    steady_run = 1'b0;
  endtask

  // Refused starts with several masks, start, hold, stop (reset register values)
  task automatic test_start_interlock();
    send_word(mk(0, 0, 0, 0, 1, 0, 0));
    send_word(mk(0, 0, 0, 0, 0, 4095, 4095));
    send_word(mk(1, 0, 0, 0, 1, 4095, 0));
    send_word(mk(1, 1, 1, 0, 0, 0, 4095));
    send_word(mk(0, 1, 1, 1, 1, 1000, 300));
    send_word(mk(1, 1, 1, 1, 0, 1000, 300));
    send_word(mk(1, 1, 1, 1, 1, 2000, 100));
    send_word(mk(1, 1, 1, 1, 1, 2000, 100));
    send_word(mk(0, 0, 0, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, 0, 1, 4095, 4095));
    send_word(mk(1, 1, 1, 1, 0, 0, 0));
    wait_drained();
  endtask

  // Band edges, entry into auto, on and off delays, stop while in auto
  task automatic test_lamp_bands();
    apply_config(make_cfg(200, 1056, 2112, 50, 50, 25));
    send_word(mk(1, 1, 1, 1, 1, 4095, 0));
    send_word(mk(1, 1, 1, 1, 0, 4095, 0));
    send_word(mk(1, 1, 1, 1, 0, 0, 0));
    send_word(mk(1, 1, 1, 1, 0, 1056, 0));
    send_word(mk(1, 1, 1, 1, 0, 2111, 0));
    send_word(mk(1, 1, 1, 1, 0, 1500, 0));
    send_word(mk(1, 1, 1, 1, 0, 1500, 4095));
    send_word(mk(1, 1, 1, 1, 0, 1500, 199));
    send_word(mk(1, 1, 1, 1, 0, 1500, 200));
    send_word(mk(1, 1, 1, 1, 0, 2112, 200));
    send_word(mk(1, 1, 1, 1, 0, 2000, 200));
    send_word(mk(1, 1, 1, 1, 1, 2000, 0));
    send_word(mk(1, 1, 1, 1, 0, 4095, 0));
    wait_drained();
  endtask

  // Random cabins over a sweep of register settings, extremes first
  task automatic test_config_sweep();
    cfg_t c;
    int   lo;
    int   hi;
    for (int k = 0; k < 7; k++) begin
      lo = $urandom_range(0, 4095);
      hi = $urandom_range(0, 4095);
      case (k)
        0: c = make_cfg(4095, 0, 4095, 0, 0, 0);
        1: c = make_cfg(0, 4095, 0, 4095, 4095, 63);
        2: c = make_cfg(2048, 1000, 3000, 100, 150, 25);
        // overlapping bands leave auto empty
        3: c = make_cfg($urandom_range(0, 4095), (lo > hi) ? lo : hi, (lo > hi) ? hi : lo,
                        $urandom_range(0, 400), $urandom_range(0, 400),
                        $urandom_range(1, 63));
        default: c = make_cfg($urandom_range(0, 4095), (lo < hi) ? lo : hi,
                              (lo < hi) ? hi : lo, $urandom_range(0, 400),
                              $urandom_range(0, 400), $urandom_range(1, 63));
      endcase
      apply_config(c);
      drive_scene(PhaseWords);
      wait_drained();
    end
  endtask

  // Result side: random stalls, compare each word with the oldest prediction
  initial begin
    int unsigned stall;
    result_t     want;
    result_t     got;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady_run ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = {ready_led_o, engine_led_o, dipped_beam_o, inhibit_pulse_o,
             missing_mask_o, welcome_pulse_o, started_pulse_o};
      if (dash_due_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = dash_due_q.pop_front();
        cmp_field("ready_led", want.ready_led, got.ready_led);
        cmp_field("engine_led", want.engine_led, got.engine_led);
        cmp_field("dipped_beam", want.dipped_beam, got.dipped_beam);
        cmp_field("inhibit_pulse", want.inhibit_pulse, got.inhibit_pulse);
        cmp_field("missing_mask", want.missing_mask, got.missing_mask);
        cmp_field("welcome_pulse", want.welcome_pulse, got.welcome_pulse);
        cmp_field("started_pulse", want.started_pulse, got.started_pulse);
      end
    end
  end

  // Sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_interlock();
    test_lamp_bands();
    test_config_sweep();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[seatbelt_interlock_auto_headlights_core.f]
src/sbia_pkg.sv
src/sbia_step.sv
src/seatbelt_interlock_auto_headlights_core.sv
tb/seatbelt_interlock_auto_headlights_core_tb.sv
